[rtl/core/jcs_pkg.sv]
`default_nettype none

package jcs_pkg;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_STRING = 2'd1;
	localparam logic [1:0] MODE_LINE   = 2'd2;
	localparam logic [1:0] MODE_BLOCK  = 2'd3;

	localparam logic [7:0] CH_SLASH     = 8'h2F;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSLASH = 8'h5C;
	localparam logic [7:0] CH_QUOTE     = 8'h22;

	// result queue depth, room for two more entries is needed to take an item
	localparam int unsigned QDepth = 3;
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       out_valid;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic       keep;
		logic       skip;
		logic [1:0] mode;
	} judge_t;

	// decide one byte c, given its raw predecessor and one byte of lookahead
	function automatic judge_t judge(input logic [1:0] mode, input logic [7:0] c,
			input logic [7:0] prev, input logic [7:0] nx);
		judge_t     r;
		logic [1:0] m;
		r.keep = 1'b0;
		r.skip = 1'b0;
		r.mode = mode;
		m = mode;
		case (mode)
			MODE_LINE: begin
				if (c == CH_NEWLINE) begin
					r.mode = MODE_NORMAL;
					r.keep = 1'b1;
				end
			end
			MODE_BLOCK: begin
				if (c == CH_STAR && nx == CH_SLASH) begin
					r.mode = MODE_NORMAL;
					r.skip = 1'b1;
				end
			end
			default: begin
				if (c == CH_QUOTE && prev != CH_BACKSLASH) begin
					m = (m == MODE_STRING) ? MODE_NORMAL : MODE_STRING;
				end
				r.keep = 1'b1;
				if (m != MODE_STRING && c == CH_SLASH) begin
					if (nx == CH_SLASH) begin
						m = MODE_LINE;
						r.keep = 1'b0;
					end else if (nx == CH_STAR) begin
						m = MODE_BLOCK;
						r.skip = 1'b1;
						r.keep = 1'b0;
					end
				end
				r.mode = m;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/core/jsonc_comment_stripper.sv]
`default_nettype none

// jsonc comment stripper
// removes // line comments (newline kept) and /* */ block comments that lie
// outside double-quoted strings from a byte stream
// input channel: in_valid / in_ready / in_data, one byte per transfer,
//   in_data.in_last marks the final byte of a stream
// output channel: res_valid / res_ready / res_data, one kept byte per transfer;
//   res_data.out_valid 0 is a bare end marker, res_data.out_last flags the
//   final transfer of a stream
// one byte is held back as lookahead, so a byte comes out when the next one
// has been taken; the final byte flushes the held byte too (up to two transfers)
// structure: input register, then the decision logic writes a three-entry result
//   queue
// throughput: one byte per cycle while the receiver keeps up; after a two-result
//   flush the input pauses while the queue drains
// receiver stall: once the queue holds two or more results, in_ready drops as
//   soon as the input register holds a byte that cannot be placed
// reset: scan state cleared to normal text, nothing held, queue empty;
//   after each final byte the scan state returns to the same values
module jsonc_comment_stripper
	import jcs_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           res_valid,
	input  wire logic      res_ready,
	output out_item_t      res_data
);

	// input register
	logic       valid_s1;
	in_item_t   item_s1;

	// scan state
	logic [1:0] mode_q;
	logic [7:0] held_q;
	logic       held_valid_q;
	logic [7:0] prev_q;

	// result queue, entry 0 is the head
	out_item_t  queue_q [QDepth];
	logic [QCntW-1:0] count_q;

	logic       advance;
	logic       pop;

	// step logic
	judge_t     j1;
	judge_t     j2;
	logic [1:0] mode1;
	logic       keep1;
	logic       skip1;
	logic [7:0] held_n;
	logic       held_valid_n;
	logic [7:0] prev_n;
	logic       keep2;
	logic [1:0] push_cnt;
	out_item_t  e0;
	out_item_t  e1;
	logic [QCntW-1:0] base;

	assign pop       = res_valid && res_ready;
	assign advance   = valid_s1 && (count_q <= QCntW'(QDepth - 2));
	assign in_ready  = !valid_s1 || advance;
	assign res_valid = (count_q != '0);
	assign res_data  = queue_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	always_comb begin
		// held byte judged against the arriving byte as lookahead
		j1 = judge(mode_q, held_q, prev_q, item_s1.in_byte);
		if (held_valid_q) begin
			mode1 = j1.mode;
			keep1 = j1.keep;
			skip1 = j1.skip;
		end else begin
			mode1 = mode_q;
			keep1 = 1'b0;
			skip1 = 1'b0;
		end

		// arriving byte is either swallowed as a delimiter half or becomes held
		if (skip1) begin
			held_valid_n = 1'b0;
			held_n       = held_q;
			prev_n       = item_s1.in_byte;
		end else begin
			held_valid_n = 1'b1;
			held_n       = item_s1.in_byte;
			prev_n       = held_valid_q ? held_q : prev_q;
		end

		// flush of the final byte with zero lookahead
		j2    = judge(mode1, held_n, prev_n, 8'h00);
		keep2 = item_s1.in_last && held_valid_n && j2.keep;

		e0 = '{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1};
		e1 = '{out_byte: held_n, out_valid: 1'b1, out_last: 1'b1};
		push_cnt = 2'd0;
		if (keep1 && keep2) begin
			e0 = '{out_byte: held_q, out_valid: 1'b1, out_last: 1'b0};
			push_cnt = 2'd2;
		end else if (keep1) begin
			e0 = '{out_byte: held_q, out_valid: 1'b1, out_last: item_s1.in_last};
			push_cnt = 2'd1;
		end else if (keep2) begin
			e0 = '{out_byte: held_n, out_valid: 1'b1, out_last: 1'b1};
			push_cnt = 2'd1;
		end else if (item_s1.in_last) begin
			// nothing kept on the final step: bare end marker
			push_cnt = 2'd1;
		end
		if (!advance) begin
			push_cnt = 2'd0;
		end
		base = pop ? (count_q - QCntW'(1)) : count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NORMAL;
			held_valid_q <= 1'b0;
			held_q       <= 8'h00;
			prev_q       <= 8'h00;
		end else if (advance) begin
			if (item_s1.in_last) begin
				// end of stream, start the next one from scratch
				mode_q       <= MODE_NORMAL;
				held_valid_q <= 1'b0;
				held_q       <= 8'h00;
				prev_q       <= 8'h00;
			end else begin
				mode_q       <= mode1;
				held_valid_q <= held_valid_n;
				held_q       <= held_n;
				prev_q       <= prev_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= base + QCntW'(push_cnt);
		end
	end

	// shift on pop, then append the new results behind the survivors
	always_ff @(posedge clk) begin
		for (int i = 0; i < QDepth; i++) begin
			if (push_cnt != 2'd0 && QCntW'(i) == base) begin
				queue_q[i] <= e0;
			end else if (push_cnt == 2'd2 && QCntW'(i) == base + QCntW'(1)) begin
				queue_q[i] <= e1;
			end else if (pop && i < QDepth - 1) begin
				queue_q[i] <= queue_q[i + 1];
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCntW'(QDepth))
		else $error("result queue count out of range");

	a_room_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		advance |-> count_q <= QCntW'(QDepth - 2))
		else $error("item taken without room for two results");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.in_last |=> mode_q == MODE_NORMAL && !held_valid_q)
		else $error("scan state not cleared after final byte");

	a_last_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.in_last |-> push_cnt != 2'd0)
		else $error("final byte produced no result");

endmodule

`default_nettype wire

[verif/tb_jsonc_comment_stripper.sv]
`default_nettype none

module tb_jsonc_comment_stripper;
	import jcs_pkg::*;

	// clock, reset and the two channels
	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      res_valid;
	logic      res_ready;
	out_item_t res_data;

	jsonc_comment_stripper dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// bytes waiting to be driven, and the kept bytes we expect back
	in_item_t    pending_bytes[$];
	out_item_t   expected_out[$];
	logic [7:0]  text_buf[$];
	int unsigned items_queued;
	int unsigned items_taken;
	int unsigned fail_count;
	int unsigned cyc;
	bit          in_took;

	// scanner state mirrored from the block
	logic [1:0] scan_mode_q;
	logic [7:0] held_q;
	logic       held_ok;
	logic [7:0] prior_q;

	// no idling on either side during this window of cycles
	function automatic bit calm_window();
		return cyc >= 1200 && cyc < 2200;
	endfunction

	function automatic bit take_break();
		return !calm_window() && $urandom_range(0, 99) < 16;
	endfunction

	// decide whether byte c survives; ahead is the lookahead byte,
	// eat_ahead says the lookahead is the second half of a delimiter
	function automatic logic keep_byte(input logic [7:0] c, input logic [7:0] before_c,
			input logic [7:0] ahead, output logic eat_ahead);
		eat_ahead = 1'b0;
		if (scan_mode_q == MODE_LINE) begin
			if (c == CH_NEWLINE) begin
				scan_mode_q = MODE_NORMAL;
				return 1'b1;
			end
			return 1'b0;
		end
		if (scan_mode_q == MODE_BLOCK) begin
			if (c == CH_STAR && ahead == CH_SLASH) begin
				scan_mode_q = MODE_NORMAL;
				eat_ahead = 1'b1;
			end
			return 1'b0;
		end
		// an escaped quote does not toggle string mode
		if (c == CH_QUOTE && before_c != CH_BACKSLASH)
			scan_mode_q = (scan_mode_q == MODE_STRING) ? MODE_NORMAL : MODE_STRING;
		if (scan_mode_q != MODE_STRING && c == CH_SLASH) begin
			if (ahead == CH_SLASH) begin
				scan_mode_q = MODE_LINE;
				return 1'b0;
			end
			if (ahead == CH_STAR) begin
				scan_mode_q = MODE_BLOCK;
				eat_ahead = 1'b1;
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic void clear_scanner();
		scan_mode_q = MODE_NORMAL;
		held_q      = 8'h00;
		held_ok     = 1'b0;
		prior_q     = 8'h00;
	endfunction

	// work out what one accepted byte releases
	task automatic predict_strip(input in_item_t it);
		out_item_t step_out[$];
		logic      eat;
		eat = 1'b0;
		if (held_ok && keep_byte(held_q, prior_q, it.in_byte, eat))
			step_out.insert(step_out.size(), '{held_q, 1'b1, 1'b0});
		if (eat) begin
			// the arriving byte closes or opens a comment and is dropped
			held_ok = 1'b0;
			prior_q = it.in_byte;
		end else begin
			if (held_ok)
				prior_q = held_q;
			held_q  = it.in_byte;
			held_ok = 1'b1;
		end
		if (it.in_last) begin
			// flush: the final byte sees a zero lookahead
			if (held_ok && keep_byte(held_q, prior_q, 8'h00, eat))
				step_out.insert(step_out.size(), '{held_q, 1'b1, 1'b0});
			if (step_out.size() == 0) begin
				step_out.insert(0, '{8'h00, 1'b0, 1'b1});
			end else begin
				step_out[step_out.size() - 1].out_last = 1'b1;
			end
			clear_scanner();
		end
		foreach (step_out[i])
			expected_out.insert(expected_out.size(), step_out[i]);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.insert(text_buf.size(), s[i]);
	endtask

	// turn the text buffer into one stream, last byte marked
	task automatic emit_stream();
		in_item_t it;
		foreach (text_buf[i]) begin
			it.in_byte = text_buf[i];
			it.in_last = (i == text_buf.size() - 1);
			pending_bytes.insert(pending_bytes.size(), it);
			items_queued++;
		end
		text_buf.delete();
	endtask

	// random stream built from comment and string fragments plus noise
	task automatic add_random_stream();
		int unsigned len;
		logic [7:0]  b;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
		while (text_buf.size() < len) begin
			case ($urandom_range(0, 11))
				0: add_text("//");
				1: add_text("/*");
				2: add_text("*/");
				3: add_text("\\\"");
				4, 5: text_buf.insert(text_buf.size(), CH_QUOTE);
				6: text_buf.insert(text_buf.size(), CH_NEWLINE);
				7: begin
					b = 8'($urandom_range(0, 255));
					text_buf.insert(text_buf.size(), b);
				end
				8: begin
					case ($urandom_range(0, 4))
						0: b = CH_SLASH;
						1: b = CH_STAR;
						2: b = CH_NEWLINE;
						3: b = CH_BACKSLASH;
						default: b = CH_QUOTE;
					endcase
					text_buf.insert(text_buf.size(), b);
				end
				default: begin
					b = 8'($urandom_range(8'h61, 8'h7a));
					text_buf.insert(text_buf.size(), b);
				end
			endcase
		end
		// fragments may overshoot, which also leaves broken delimiters at the end
		while (text_buf.size() > len)
			void'(text_buf.pop_back());
		emit_stream();
	endtask

	task automatic wait_drained();
		while (items_taken != items_queued || expected_out.size() != 0)
			@(negedge clk);
	endtask

	// sender: new byte at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_took) begin
				in_took = 1'b0;
				if (pending_bytes.size() != 0 && !take_break()) begin
					in_data  <= pending_bytes.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			res_ready <= !take_break();
		end
	end

	// monitor: predict on every input transfer, check every result transfer
	always @(posedge clk) begin
		out_item_t want;
		cyc++;
		if (arst_n && in_valid && in_ready) begin
			predict_strip(in_data);
			items_taken++;
			in_took = 1'b1;
		end
		if (arst_n && res_valid && res_ready) begin
			if (expected_out.size() == 0) begin
				$display("%0t: unexpected result byte=%h valid=%b last=%b", $time,
					res_data.out_byte, res_data.out_valid, res_data.out_last);
				fail_count++;
			end else begin
				want = expected_out.pop_front();
				if (res_data.out_byte !== want.out_byte ||
						res_data.out_valid !== want.out_valid ||
						res_data.out_last !== want.out_last) begin
					$display("%0t: mismatch expected byte=%h valid=%b last=%b, %s",
						$time, want.out_byte, want.out_valid, want.out_last,
						$sformatf("got byte=%h valid=%b last=%b",
						res_data.out_byte, res_data.out_valid, res_data.out_last));
					fail_count++;
				end
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		res_ready    = 1'b0;
		in_took      = 1'b0;
		items_queued = 0;
		items_taken  = 0;
		fail_count   = 0;
		cyc          = 0;
		clear_scanner();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed streams
		add_text("\"");              // quote as the very first byte toggles
		emit_stream();
		add_text("/");               // trailing slash judged against zero lookahead
		emit_stream();
		add_text("a//b\n");          // line comment, newline survives
		emit_stream();
		add_text("/**/z");           // both delimiter halves swallowed
		emit_stream();
		add_text("\"\\\"/*\"");      // escaped quote keeps us inside the string
		emit_stream();
		add_text("/*x");             // unfinished block comment, bare end marker only
		emit_stream();
		text_buf.insert(text_buf.size(), 8'hFF);   // byte extremes
		text_buf.insert(text_buf.size(), 8'h00);
		emit_stream();

		// hold the sender until everything directed has come back
		wait_drained();

		while (items_queued < 1700)
			add_random_stream();

		wait_drained();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && expected_out.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			if (expected_out.size() != 0)
				$display("%0t: %0d expected results never arrived", $time, expected_out.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
